// ===== hdl/okt_pkg.sv =====
// ----------------------------------------------------------------------------
// okt_pkg
// Shared types and codes for the ordered key table.
// ----------------------------------------------------------------------------
package okt_pkg;

	localparam int KEY_W    = 32;
	localparam int ACTION_W = 3;
	localparam int STATUS_W = 2;

	localparam logic [ACTION_W-1:0] ACT_SEARCH = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_NEXT   = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_PREV   = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_FIRST  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_LAST   = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd6;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;      // capture request, reset search bounds
		logic bs_step;   // one binary search step
		logic rd_issue;  // read store at rd address
		logic rd_sel;    // 0: read at mid on a search step, else at pos; 1: read at target index
		logic sh_step;   // one shift step
		logic sh_up;     // 1: insert shift, 0: remove shift
		logic wr_new;    // write new entry at pos
		logic cnt_inc;
		logic cnt_dec;
		logic res_load;  // latch result from read data
		logic res_zero;  // latch result with zero fields
		logic res_new;   // latch result from request
		logic res_old;   // latch result with request key and old payload
		logic [STATUS_W-1:0] res_status;
		logic cap_old;   // capture removed payload
		logic tgt_load;  // compute target index
	} okt_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic bs_done;   // search bounds met
		logic probe_lt;  // probed key below request key
		logic match;     // entry at pos equals request key
		logic tgt_ok;    // target index holds a valid entry
		logic sh_done;   // shift finished
		logic full;
		logic pos_zero;
		logic empty;
		logic [ACTION_W-1:0] action;
	} okt_stat_t;

endpackage

// ===== hdl/ordered_key_table.sv =====
// ----------------------------------------------------------------------------
// ordered_key_table
// Ordered map of unique signed keys with data words, in a sorted store.
// ----------------------------------------------------------------------------
// Usage: one request channel (in_valid/in_stall with action, key, payload)
// and one result channel (out_valid/out_stall with status, hit_key,
// hit_payload). Each request gives exactly one result.
// Sequence: a search narrows the bounds over the valid entries by binary
// search, alternating a probe and a step, then reads the entry at pos and
// decides; next, previous, first and last read one more entry at the
// target index before they answer. Insert and remove move one entry per
// cycle through the store, from the tail down to pos (insert) or from pos
// up to the tail (remove).
// One request is worked at a time; the next can be taken in the cycle in
// which the result appears.
// Reset clears the entry count and the controller; the store itself
// needs no clearing since only valid entries are ever used.
// While the receiver stalls, the result holds; a following request may
// search, then holds at its decide step until the result is taken.
// ----------------------------------------------------------------------------
module ordered_key_table #(
	parameter int CAPACITY      = 64,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [2:0]                action,
	input  logic signed [31:0]        key,
	input  logic [31:0]               payload,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                status,
	output logic signed [31:0]        hit_key,
	output logic [31:0]               hit_payload
);
	import okt_pkg::*;

	okt_cmd_t                 cmd;
	okt_stat_t                stat;
	logic [PAYLOAD_WIDTH-1:0] in_pay;
	logic [PAYLOAD_WIDTH-1:0] res_pay;

	// Keep the low data bits, or zero-extend when the store is wider.
	assign in_pay = PAYLOAD_WIDTH'(payload);

	// Sequencer: drives the handshake and steps the datapath.
	okt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: stores, bounds and the result register.
	okt_datapath #(
		.CAPACITY      (CAPACITY),
		.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_action   (action),
		.in_key      (key),
		.in_payload  (in_pay),
		.res_status  (status),
		.res_key     (hit_key),
		.res_payload (res_pay)
	);

	// Bring the kept data bits back to the port width.
	assign hit_payload = 32'(res_pay);

endmodule

// ===== hdl/okt_datapath.sv =====
// ----------------------------------------------------------------------------
// okt_datapath
// Sorted key and data stores, search bounds, shift pointer, result register.
// ----------------------------------------------------------------------------
module okt_datapath #(
	parameter int CAPACITY      = 64,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  okt_pkg::okt_cmd_t           cmd,
	output okt_pkg::okt_stat_t          stat,
	input  logic [2:0]                  in_action,
	input  logic signed [31:0]          in_key,
	input  logic [PAYLOAD_WIDTH-1:0]    in_payload,
	output logic [1:0]                  res_status,
	output logic signed [31:0]          res_key,
	output logic [PAYLOAD_WIDTH-1:0]    res_payload
);
	import okt_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic signed [KEY_W-1:0]    key_mem [CAPACITY];
	logic [PAYLOAD_WIDTH-1:0]   pay_mem [CAPACITY];

	logic [ACTION_W-1:0]        action_q;
	logic signed [KEY_W-1:0]    key_q;
	logic [PAYLOAD_WIDTH-1:0]   pay_q;
	logic [PAYLOAD_WIDTH-1:0]   old_q;
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              lo_q;
	logic [CW-1:0]              hi_q;
	logic [CW-1:0]              tgt_q;
	logic [CW-1:0]              sh_q;
	logic signed [KEY_W-1:0]    rd_key_q;
	logic [PAYLOAD_WIDTH-1:0]   rd_pay_q;

	logic [CW-1:0]              mid;
	logic [CW-1:0]              rd_addr;
	logic [CW-1:0]              tgt_d;
	logic [CW-1:0]              sh_src;

	assign mid     = lo_q + ((hi_q - lo_q) >> 1);
	assign rd_addr = cmd.rd_sel ? tgt_q : (cmd.bs_step ? mid : lo_q);

	always_comb begin
		case (action_q)
			ACT_NEXT:   tgt_d = stat.match ? lo_q + CW'(1) : lo_q;
			ACT_PREV:   tgt_d = lo_q - CW'(1);
			ACT_FIRST:  tgt_d = '0;
			ACT_LAST:   tgt_d = count_q - CW'(1);
			default:    tgt_d = lo_q;
		endcase
	end

	// Shift source: insert moves entry sh-1 up to sh, remove moves sh+1 down to sh.
	assign sh_src = cmd.sh_up ? sh_q - CW'(1) : sh_q + CW'(1);

	always_ff @(posedge clk) begin
		if (cmd.sh_step) begin
			rd_key_q <= key_mem[sh_src[IW-1:0]];
			rd_pay_q <= pay_mem[sh_src[IW-1:0]];
		end else if (cmd.rd_issue) begin
			rd_key_q <= key_mem[rd_addr[IW-1:0]];
			rd_pay_q <= pay_mem[rd_addr[IW-1:0]];
		end
	end

	// Shift pipeline: read at step, write in the cycle after.
	logic            wr_pend_q;
	logic [CW-1:0]   wr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pend_q <= 1'b0;
		end else begin
			wr_pend_q <= cmd.sh_step;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sh_step)
			wr_addr_q <= sh_q;
		if (wr_pend_q) begin
			key_mem[wr_addr_q[IW-1:0]] <= rd_key_q;
			pay_mem[wr_addr_q[IW-1:0]] <= rd_pay_q;
		end else if (cmd.wr_new) begin
			key_mem[lo_q[IW-1:0]] <= key_q;
			pay_mem[lo_q[IW-1:0]] <= pay_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= in_action;
			key_q    <= in_key;
			pay_q    <= in_payload;
			lo_q     <= '0;
			hi_q     <= count_q;
			sh_q     <= (in_action == ACT_INSERT) ? count_q : '0;
		end else begin
			if (cmd.bs_step) begin
				if (stat.probe_lt)
					lo_q <= mid + CW'(1);
				else
					hi_q <= mid;
			end
			if (cmd.tgt_load) begin
				tgt_q <= tgt_d;
				if (action_q == ACT_REMOVE)
					sh_q <= lo_q;
			end
			if (cmd.sh_step)
				sh_q <= sh_src;
		end
		if (cmd.cap_old)
			old_q <= rd_pay_q;
	end

	// Probe compare uses data registered from the previous mid read.
	logic signed [KEY_W-1:0] probe_key_q;
	logic                    probe_ok_q;
	always_ff @(posedge clk) begin
		probe_key_q <= key_mem[mid[IW-1:0]];
		probe_ok_q  <= 1'b1;
	end

	assign stat.probe_lt = probe_ok_q && (probe_key_q < key_q);
	assign stat.bs_done  = (lo_q == hi_q);
	assign stat.match    = (lo_q < count_q) && (rd_key_q == key_q);
	assign stat.tgt_ok   = (tgt_q < count_q);
	assign stat.sh_done  = cmd.sh_up ? (sh_q == lo_q) : (sh_q + CW'(1) >= count_q);
	assign stat.full     = (count_q == CW'(CAPACITY));
	assign stat.pos_zero = (lo_q == '0);
	assign stat.empty    = (count_q == '0);
	assign stat.action   = action_q;

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status  <= cmd.res_status;
			res_key     <= rd_key_q;
			res_payload <= rd_pay_q;
		end else if (cmd.res_zero) begin
			res_status  <= cmd.res_status;
			res_key     <= '0;
			res_payload <= '0;
		end else if (cmd.res_new) begin
			res_status  <= cmd.res_status;
			res_key     <= key_q;
			res_payload <= pay_q;
		end else if (cmd.res_old) begin
			res_status  <= cmd.res_status;
			res_key     <= key_q;
			res_payload <= old_q;
		end
	end

endmodule

// ===== hdl/okt_ctrl.sv =====
// ----------------------------------------------------------------------------
// okt_ctrl
// Sequencer: search, read, shift, respond.
// ----------------------------------------------------------------------------
module okt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  okt_pkg::okt_stat_t   stat,
	output okt_pkg::okt_cmd_t    cmd
);
	import okt_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PROBE = 4'd1; // mid read in flight
	localparam logic [3:0] S_STEP  = 4'd2; // narrow bounds
	localparam logic [3:0] S_RDPOS = 4'd3; // read entry at pos
	localparam logic [3:0] S_DEC   = 4'd4; // decide action
	localparam logic [3:0] S_RDTGT = 4'd5;
	localparam logic [3:0] S_TGT   = 4'd6;
	localparam logic [3:0] S_SHIFT = 4'd7;
	localparam logic [3:0] S_FLUSH = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       up_q;
	logic       up_d;

	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != S_IDLE);

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		up_d     = up_q;
		cmd.sh_up = up_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_PROBE;
				end
			end
			S_PROBE: begin
				state_d = stat.bs_done ? S_RDPOS : S_STEP;
			end
			S_STEP: begin
				cmd.bs_step = 1'b1;
				state_d     = S_PROBE;
			end
			S_RDPOS: begin
				cmd.rd_issue = 1'b1;
				state_d      = S_DEC;
			end
			S_DEC: begin
				cmd.tgt_load = 1'b1;
				case (stat.action)
					ACT_SEARCH: begin
						cmd.res_status = stat.match ? ST_OK : ST_MISS;
						cmd.res_load   = stat.match;
						cmd.res_zero   = !stat.match;
						state_d        = S_OUT;
					end
					ACT_NEXT, ACT_FIRST: state_d = S_RDTGT;
					ACT_PREV: begin
						if (stat.pos_zero) begin
							cmd.res_status = ST_MISS;
							cmd.res_zero   = 1'b1;
							state_d        = S_OUT;
						end else begin
							state_d = S_RDTGT;
						end
					end
					ACT_LAST: begin
						if (stat.empty) begin
							cmd.res_status = ST_MISS;
							cmd.res_zero   = 1'b1;
							state_d        = S_OUT;
						end else begin
							state_d = S_RDTGT;
						end
					end
					ACT_INSERT: begin
						if (stat.match) begin
							cmd.res_status = ST_DUP;
							cmd.res_load   = 1'b1;
							state_d        = S_OUT;
						end else if (stat.full) begin
							cmd.res_status = ST_FULL;
							cmd.res_zero   = 1'b1;
							state_d        = S_OUT;
						end else begin
							up_d    = 1'b1;
							state_d = S_SHIFT;
						end
					end
					ACT_REMOVE: begin
						if (!stat.match) begin
							cmd.res_status = ST_MISS;
							cmd.res_zero   = 1'b1;
							state_d        = S_OUT;
						end else begin
							cmd.cap_old = 1'b1;
							up_d        = 1'b0;
							state_d     = S_SHIFT;
						end
					end
					default: begin
						cmd.res_status = ST_MISS;
						cmd.res_zero   = 1'b1;
						state_d        = S_OUT;
					end
				endcase
			end
			S_RDTGT: begin
				cmd.rd_issue = 1'b1;
				cmd.rd_sel   = 1'b1;
				state_d      = S_TGT;
			end
			S_TGT: begin
				cmd.res_status = stat.tgt_ok ? ST_OK : ST_MISS;
				cmd.res_load   = stat.tgt_ok;
				cmd.res_zero   = !stat.tgt_ok;
				state_d        = S_OUT;
			end
			S_SHIFT: begin
				// Move one entry per cycle until the gap reaches pos (insert)
				// or the tail (remove).
				if (stat.sh_done) begin
					state_d = S_FLUSH;
				end else begin
					cmd.sh_step = 1'b1;
				end
			end
			S_FLUSH: begin
				cmd.res_status = ST_OK;
				if (up_q) begin
					cmd.wr_new  = 1'b1;
					cmd.cnt_inc = 1'b1;
					cmd.res_new = 1'b1;
				end else begin
					cmd.cnt_dec = 1'b1;
					cmd.res_old = 1'b1;
				end
				state_d = S_OUT;
			end
			S_OUT: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		// Hold before touching the result register while the previous
		// result still waits for the receiver.
		if (out_valid_q && (state_q inside {S_DEC, S_TGT, S_FLUSH})) begin
			cmd       = '0;
			cmd.sh_up = up_q;
			state_d   = state_q;
			up_d      = up_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			up_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			up_q    <= up_d;
			if (state_q == S_OUT)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== verif/tb_ordered_key_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_key_table
// Self-checking bench for the ordered key table. Requests go in through the
// valid/stall handshake and a predictor that keeps its own sorted copy of the
// table works out each result. A monitor compares every accepted result,
// field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_ordered_key_table;

	import okt_pkg::*;

	localparam int CAP       = 64;
	localparam int WDOG_MAX  = 20000;
	localparam int DRAIN_CYC = 200;

	localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic signed [31:0]  hit_key;
		logic [31:0]         hit_payload;
	} result_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [2:0]          action;
	logic signed [31:0]  key;
	logic [31:0]         payload;
	logic                out_valid;
	logic                out_stall;
	logic [1:0]          status;
	logic signed [31:0]  hit_key;
	logic [31:0]         hit_payload;

	// Predictor copy of the table: sorted ascending by signed key.
	logic signed [31:0]  tbl_key[$];
	logic [31:0]         tbl_pay[$];
	result_t             pending_results[$];

	int  errors;
	int  send_idle_pct;
	int  recv_stall_pct;
	int  quiet_cycles;

	ordered_key_table u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.key         (key),
		.payload     (payload),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.hit_key     (hit_key),
		.hit_payload (hit_payload)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Count of stored keys strictly below k.
	function automatic int rank_below(logic signed [31:0] k);
		int n;
		n = 0;
		while (n < tbl_key.size() && tbl_key[n] < k) n++;
		return n;
	endfunction

	function automatic result_t entry_at(int idx, logic [STATUS_W-1:0] st);
		result_t r;
		if (idx < 0 || idx >= tbl_key.size()) begin
			r = '{ST_MISS, 32'sd0, 32'd0};
		end else begin
			r = '{st, tbl_key[idx], tbl_pay[idx]};
		end
		return r;
	endfunction

	// Apply one request to the table copy and return its result.
	function automatic result_t predict_lookup(logic [2:0] act, logic signed [31:0] k,
			logic [31:0] p);
		int      pos;
		bit      hit;
		result_t r;
		pos = rank_below(k);
		hit = (pos < tbl_key.size()) && (tbl_key[pos] == k);
		r   = '{ST_MISS, 32'sd0, 32'd0};
		case (act)
			ACT_SEARCH: if (hit) r = entry_at(pos, ST_OK);
			ACT_NEXT:   r = entry_at(hit ? pos + 1 : pos, ST_OK);
			ACT_PREV:   if (pos != 0) r = entry_at(pos - 1, ST_OK);
			ACT_FIRST:  r = entry_at(0, ST_OK);
			ACT_LAST:   r = entry_at(tbl_key.size() - 1, ST_OK);
			ACT_INSERT: begin
				if (hit) begin
					r = entry_at(pos, ST_DUP);
				end else if (tbl_key.size() >= CAP) begin
					r = '{ST_FULL, 32'sd0, 32'd0};
				end else begin
					tbl_key.insert(pos, k);
					tbl_pay.insert(pos, p);
					r = '{ST_OK, k, p};
				end
			end
			ACT_REMOVE: begin
				if (hit) begin
					r = '{ST_OK, k, tbl_pay[pos]};
					tbl_key.delete(pos);
					tbl_pay.delete(pos);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Drive one request, hold it until accepted, then predict its result.
	// Valid stays high after acceptance; an idle cycle or a drain drops it.
	task automatic send_request(logic [2:0] act, logic signed [31:0] k, logic [31:0] p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		action   <= act;
		key      <= k;
		payload  <= p;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(predict_lookup(act, k, p));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Keys drawn from a small pool so that hits and duplicates are common.
	function automatic logic signed [31:0] pick_key();
		case ($urandom_range(3))
			0:       return $signed($urandom());
			1:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(40)) - 32'sd20;
		endcase
	endfunction

	// Receiver: stall at random, check each result as it is taken.
	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result status=%0d key=%0d payload=%h",
						$time, status, hit_key, hit_payload);
					errors++;
				end else begin
					exp_r = pending_results.pop_front();
					if (status !== exp_r.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, exp_r.status, status);
						errors++;
					end
					if (hit_key !== exp_r.hit_key) begin
						$display("%0t: hit_key expected %0d actual %0d",
							$time, exp_r.hit_key, hit_key);
						errors++;
					end
					if (hit_payload !== exp_r.hit_payload) begin
						$display("%0t: hit_payload expected %h actual %h",
							$time, exp_r.hit_payload, hit_payload);
						errors++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog: end the run if no handshake happens for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WDOG_MAX) begin
				$display("ordered_key_table regression: fail");
				$finish;
			end
		end
	end

	// Empty table: every lookup misses, remove misses, unused action ignored.
	task automatic test_empty_table();
		send_request(ACT_SEARCH, 32'sd0, 32'd0);
		send_request(ACT_NEXT, 32'sh80000000, 32'd0);
		send_request(ACT_PREV, 32'sh7fffffff, 32'd0);
		send_request(ACT_FIRST, 32'sd0, 32'd0);
		send_request(ACT_LAST, 32'sd0, 32'd0);
		send_request(ACT_REMOVE, 32'sd5, 32'd0);
		send_request(ACT_UNUSED, 32'sd5, 32'hffffffff);
	endtask

	// Key extremes, duplicate insert, next/previous around and between keys.
	task automatic test_extremes();
		send_request(ACT_INSERT, 32'sh7fffffff, 32'hffffffff);
		send_request(ACT_INSERT, 32'sh80000000, 32'h00000000);
		send_request(ACT_INSERT, 32'sd0, 32'ha5a5a5a5);
		send_request(ACT_INSERT, 32'sd0, 32'h5a5a5a5a);
		send_request(ACT_FIRST, 32'sd0, 32'd0);
		send_request(ACT_LAST, 32'sd0, 32'd0);
		send_request(ACT_NEXT, 32'sd0, 32'd0);
		send_request(ACT_NEXT, 32'sd1, 32'd0);
		send_request(ACT_NEXT, 32'sh7fffffff, 32'd0);
		send_request(ACT_PREV, 32'sh80000000, 32'd0);
		send_request(ACT_PREV, -32'sd1, 32'd0);
		send_request(ACT_SEARCH, 32'sh7fffffff, 32'd0);
		send_request(ACT_REMOVE, 32'sd0, 32'd0);
		send_request(ACT_REMOVE, 32'sd0, 32'd0);
		send_request(ACT_UNUSED, 32'sh7fffffff, 32'd0);
	endtask

	// Fill to capacity, try one new key and one duplicate, then empty it again.
	task automatic test_full_table();
		int i;
		for (i = 0; tbl_key.size() < CAP; i++)
			send_request(ACT_INSERT, $signed(i * 7919 - 200000), $urandom());
		send_request(ACT_INSERT, 32'sd12345, 32'd1);
		send_request(ACT_INSERT, tbl_key[CAP/2], 32'd1);
		wait_drained();
		while (tbl_key.size() > 0)
			send_request(ACT_REMOVE, tbl_key[$urandom_range(tbl_key.size() - 1)], 32'd0);
	endtask

	task automatic test_random_mix(int count);
		int i;
		int pick;
		for (i = 0; i < count; i++) begin
			pick = $urandom_range(9);
			if (pick < 4) begin
				send_request(ACT_INSERT, pick_key(), $urandom());
			end else if (pick < 6 && tbl_key.size() > 0) begin
				send_request(ACT_REMOVE, tbl_key[$urandom_range(tbl_key.size() - 1)], 32'd0);
			end else if (pick == 9) begin
				send_request(3'($urandom_range(ACT_UNUSED)), pick_key(), $urandom());
			end else begin
				send_request(3'($urandom_range(ACT_REMOVE)), pick_key(), $urandom());
			end
		end
	endtask

	initial begin
		errors         = 0;
		quiet_cycles   = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		action         = '0;
		key            = '0;
		payload        = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_extremes();
		test_full_table();

		// Hold off until the table is quiet, then run the random phases, plain and with idles and stalls.
		wait_drained();
		test_random_mix(115);
		send_idle_pct = 84;
		test_random_mix(115);
		send_idle_pct  = 0;
		recv_stall_pct = 84;
		test_random_mix(115);
		send_idle_pct  = 9;
		recv_stall_pct = 9;
		test_random_mix(115);

		wait_drained();
		repeat (DRAIN_CYC) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("ordered_key_table regression: pass");
		end else begin
			$display("ordered_key_table regression: fail");
		end
		$finish;
	end

endmodule
